@@ rtl/smp_pkg.sv @@
// Shared types and constants for the substring match positions block.
// Used by smp_cell, smp_out_fifo and substring_match_positions_unit.
`default_nettype none

package smp_pkg;

  localparam int MAX_PATTERN   = 64;
  localparam int POSITION_BITS = 32;
  localparam int SYMBOL_BITS   = 8;
  localparam int OUT_BITS      = 32;

  localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef logic [1:0]               op_t;
  typedef logic [SYMBOL_BITS-1:0]   symbol_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LEN_BITS-1:0]      len_t;

  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_APPEND = 2'd1;
  localparam op_t OP_TEXT   = 2'd2;

  localparam pos_t POS_MAX = '1;

  typedef struct packed {
    op_t     operation;
    symbol_t symbol;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] match_start;
    logic [OUT_BITS-1:0] match_count;
  } out_item_t;

  // Broadcast to every cell of the chain for one accepted transaction.
  typedef struct packed {
    logic    clear;
    logic    append;
    logic    text;
    symbol_t symbol;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/smp_cell.sv @@
// One pattern cell: a stored pattern byte and its partial match bit.
// Depends on smp_pkg for the control struct and symbol type.
`default_nettype none

module smp_cell (
  input  logic               clk,
  input  logic               rst,
  input  smp_pkg::cell_ctrl_t ctrl,
  input  logic               sel,
  input  logic               active,
  input  logic               prev_hit,
  output logic               hit
);

  smp_pkg::symbol_t sym_q;

  always_ff @(posedge clk) begin
    if (ctrl.append && sel) begin
      sym_q <= ctrl.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.clear) begin
      hit <= 1'b0;
    end else if (ctrl.append && sel) begin
      hit <= 1'b0;
    end else if (ctrl.text && active) begin
      // extend the neighbor's prefix match by this byte
      hit <= prev_hit && (sym_q == ctrl.symbol);
    end
  end

endmodule

`default_nettype wire

@@ rtl/smp_out_fifo.sv @@
// Small result queue between the match stage and the output channel.
// Depends on smp_pkg for the result struct and queue sizing.
`default_nettype none

module smp_out_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  smp_pkg::out_item_t                  push_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output smp_pkg::out_item_t                  out_data,
  output logic [smp_pkg::FIFO_CNT_BITS-1:0]   count
);

  smp_pkg::out_item_t                 entries [smp_pkg::FIFO_DEPTH];
  logic [smp_pkg::FIFO_PTR_BITS-1:0]  wr_ptr;
  logic [smp_pkg::FIFO_PTR_BITS-1:0]  rd_ptr;
  logic                               pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/substring_match_positions_unit.sv @@
// Streaming exact string matcher: a chain of pattern cells plus counters.
// Depends on smp_pkg, smp_cell and smp_out_fifo.
//
// Input channel (in_valid, in_stall, in_data): each transaction is a clear,
// a pattern byte append, or a text byte. Appends beyond MAX_PATTERN bytes
// and operation code 3 are dropped. Output channel (out_valid, out_stall,
// out_data): one transaction per text byte that completes an occurrence,
// carrying its one-based start position and the saturating match count.
// Throughput: one input transaction per cycle while in_stall is low; every cell
// compares its byte and takes its neighbor's partial match bit in the same
// cycle, so the rate does not depend on pattern length.
// Path: a text byte updates the cell chain and the check_valid register;
// the match check then writes the result and the count update into the
// output queue, whose count register drives out_valid.
// Reset: pattern empty, position and count zero, output queue empty; the
// block takes input as soon as reset is released.
// Receiver stall: results wait in a four-entry queue; in_stall rises when
// the queue plus the result in flight reach three, so nothing is lost.
`default_nettype none

module substring_match_positions_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  smp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output smp_pkg::out_item_t  out_data
);

  localparam int CNT_W = smp_pkg::FIFO_CNT_BITS;

  logic                          accept;
  smp_pkg::cell_ctrl_t           ctrl;
  smp_pkg::len_t                 pattern_length;
  smp_pkg::len_t                 len_m1;
  logic [smp_pkg::IDX_BITS-1:0]  last_idx;
  smp_pkg::pos_t                 text_position;
  smp_pkg::pos_t                 found_count;
  smp_pkg::pos_t                 found_count_next;
  smp_pkg::pos_t                 start_pos;
  logic [smp_pkg::MAX_PATTERN-1:0] cell_hit;
  logic                          check_valid;
  logic                          match;
  smp_pkg::out_item_t            result;
  logic [CNT_W-1:0]              fifo_count;

  assign accept = in_valid && !in_stall;

  always_comb begin
    ctrl.clear  = accept && (in_data.operation == smp_pkg::OP_CLEAR);
    ctrl.append = accept && (in_data.operation == smp_pkg::OP_APPEND);
    ctrl.text   = accept && (in_data.operation == smp_pkg::OP_TEXT);
    ctrl.symbol = in_data.symbol;
  end

  for (genvar j = 0; j < smp_pkg::MAX_PATTERN; j++) begin : g_cell
    logic prev_hit;
    if (j == 0) begin : g_head
      assign prev_hit = 1'b1;
    end else begin : g_link
      assign prev_hit = cell_hit[j-1];
    end

    smp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sel      (pattern_length == smp_pkg::LEN_BITS'(j)),
      .active   (pattern_length >  smp_pkg::LEN_BITS'(j)),
      .prev_hit (prev_hit),
      .hit      (cell_hit[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      text_position  <= '0;
      check_valid    <= 1'b0;
    end else begin
      check_valid <= ctrl.text;
      if (ctrl.clear) begin
        pattern_length <= '0;
        text_position  <= '0;
      end else if (ctrl.append) begin
        if (pattern_length < smp_pkg::LEN_BITS'(smp_pkg::MAX_PATTERN)) begin
          pattern_length <= pattern_length + 1'b1;
        end
      end else if (ctrl.text) begin
        if (text_position != smp_pkg::POS_MAX) begin
          text_position <= text_position + 1'b1;
        end
      end
    end
  end

  // Check the last active cell in the cycle after a text byte is accepted, once the chain holds its update.
  assign len_m1   = pattern_length - 1'b1;
  assign last_idx = len_m1[smp_pkg::IDX_BITS-1:0];
  assign match    = check_valid && ((pattern_length == '0) || cell_hit[last_idx]);

  assign found_count_next = (found_count == smp_pkg::POS_MAX) ? found_count
                                                              : found_count + 1'b1;
  assign start_pos = text_position - smp_pkg::pos_t'(pattern_length) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      found_count <= '0;
    end else if (ctrl.clear) begin
      found_count <= '0;
    end else if (match) begin
      found_count <= found_count_next;
    end
  end

  always_comb begin
    result.match_start = smp_pkg::OUT_BITS'(start_pos);
    result.match_count = smp_pkg::OUT_BITS'(found_count_next);
  end

  smp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (match),
    .push_data (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  // Hold input while the queue might not fit the result still in flight.
  assign in_stall = (fifo_count + CNT_W'(check_valid)) >= CNT_W'(smp_pkg::FIFO_DEPTH - 1);

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_W'(smp_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> (pattern_length == '0) && (text_position == '0) && (found_count == '0))
    else $error("clear did not reset pattern and counters");

  a_text_check: assert property (@(posedge clk) disable iff (rst)
    ctrl.text |=> check_valid)
    else $error("text byte not followed by match check");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (check_valid && (pattern_length == '0)) |-> match)
    else $error("empty pattern must match every text byte");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    match |-> (fifo_count < CNT_W'(smp_pkg::FIFO_DEPTH)))
    else $error("result pushed into full queue");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for substring_match_positions_unit: clocked driver and
// monitor around a matcher predictor kept in step with the accepted input.
// Depends on smp_pkg and the RTL of the unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam smp_pkg::op_t OP_UNUSED      = 2'd3;
  localparam int           ITEM_TARGET     = 850;
  localparam int           DRAIN_CYCLES    = 8;
  localparam int           WATCHDOG_LIMIT  = 2000;

  typedef struct {
    smp_pkg::in_item_t data;
    int                gap;
  } source_item_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  smp_pkg::in_item_t   in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  smp_pkg::out_item_t  out_data;

  source_item_t       pending_items [$];
  smp_pkg::out_item_t expected_hits [$];
  int                 errors       = 0;
  int                 fed          = 0;
  int                 wait_cycles  = 0;
  int                 stall_left   = 0;
  int                 stuck_cycles = 0;
  bit                 source_calm  = 1'b0;
  bit                 sink_calm    = 1'b0;

  // Matcher state: pattern bytes, one prefix-match bit per cell, counters.
  smp_pkg::symbol_t                pat_bytes [smp_pkg::MAX_PATTERN];
  int                              pat_len     = 0;
  logic [smp_pkg::MAX_PATTERN-1:0] prefix_hits = '0;
  smp_pkg::pos_t                   text_pos    = '0;
  smp_pkg::pos_t                   hit_total   = '0;

  substring_match_positions_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic int draw_idle();
    if ($urandom_range(0, 1) == 0) return 0;
    return int'($urandom_range(0, 16));
  endfunction

  task automatic match_transaction(smp_pkg::in_item_t t);
    logic [smp_pkg::MAX_PATTERN-1:0] nxt;
    smp_pkg::out_item_t              hit;
    case (t.operation)
      smp_pkg::OP_CLEAR: begin
        pat_len     = 0;
        prefix_hits = '0;
        text_pos    = '0;
        hit_total   = '0;
      end
      smp_pkg::OP_APPEND: begin
        if (pat_len < smp_pkg::MAX_PATTERN) begin
          pat_bytes[pat_len]   = t.symbol;
          prefix_hits[pat_len] = 1'b0;
          pat_len++;
        end
      end
      smp_pkg::OP_TEXT: begin
        if (text_pos != smp_pkg::POS_MAX) text_pos++;
        nxt = '0;
        // Cell j extends the match of cell j-1 by one byte.
        for (int j = 0; j < pat_len; j++) begin
          nxt[j] = ((j == 0) ? 1'b1 : prefix_hits[j-1]) && (pat_bytes[j] == t.symbol);
        end
        prefix_hits = nxt;
        if (pat_len == 0 || prefix_hits[pat_len-1]) begin
          if (hit_total != smp_pkg::POS_MAX) hit_total++;
          hit.match_start = smp_pkg::OUT_BITS'(
              smp_pkg::pos_t'(text_pos - smp_pkg::pos_t'(pat_len) + 1'b1));
          hit.match_count = smp_pkg::OUT_BITS'(hit_total);
          expected_hits.insert(expected_hits.size(), hit);
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_item(smp_pkg::op_t op, smp_pkg::symbol_t sym);
    source_item_t it;
    it.data.operation = op;
    it.data.symbol    = sym;
    it.gap            = source_calm ? 0 : draw_idle();
    pending_items.insert(pending_items.size(), it);
    if (op != OP_UNUSED) fed++;
  endtask

  // Driver: present the next transaction once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      wait_cycles = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) match_transaction(in_data);
      if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (wait_cycles < pending_items[0].gap) begin
        wait_cycles++;
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_items[0].data;
        in_valid <= 1'b1;
        void'(pending_items.pop_front());
        wait_cycles = 0;
      end
    end
  end

  // Monitor: check each result against the oldest expectation, then maybe stall.
  always @(posedge clk) begin : monitor
    smp_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual start %0d count %0d",
                   $time, out_data.match_start, out_data.match_count);
        end else begin
          want = expected_hits.pop_front();
          if (out_data.match_start !== want.match_start) begin
            errors++;
            $display("%0t: match_start expected %0d actual %0d",
                     $time, want.match_start, out_data.match_start);
          end
          if (out_data.match_count !== want.match_count) begin
            errors++;
            $display("%0t: match_count expected %0d actual %0d",
                     $time, want.match_count, out_data.match_count);
          end
        end
        stall_left = sink_calm ? 0 : draw_idle();
        if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("substring_match_positions_unit verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    smp_pkg::symbol_t alpha [3];
    smp_pkg::symbol_t motif [$];
    int               plen;
    int               tlen;
    int               r;

    // Empty pattern: every text byte is an occurrence.
    push_item(smp_pkg::OP_CLEAR, 8'hFF);
    push_item(smp_pkg::OP_TEXT, 8'h00);
    push_item(smp_pkg::OP_TEXT, 8'hFF);
    push_item(OP_UNUSED, 8'hA5);
    // Separator byte in pattern and text is an ordinary byte.
    push_item(smp_pkg::OP_APPEND, 8'h23);
    push_item(smp_pkg::OP_APPEND, 8'hFF);
    push_item(smp_pkg::OP_TEXT, 8'h23);
    push_item(smp_pkg::OP_TEXT, 8'hFF);
    push_item(smp_pkg::OP_TEXT, 8'h23);
    push_item(OP_UNUSED, 8'h5A);
    push_item(smp_pkg::OP_TEXT, 8'hFF);
    // Grow the pattern in the middle of the text.
    push_item(smp_pkg::OP_APPEND, 8'h23);
    push_item(smp_pkg::OP_TEXT, 8'h23);
    push_item(smp_pkg::OP_TEXT, 8'hFF);
    push_item(smp_pkg::OP_TEXT, 8'h23);
    // Self-overlapping occurrences.
    push_item(smp_pkg::OP_CLEAR, 8'h00);
    push_item(smp_pkg::OP_APPEND, 8'h00);
    push_item(smp_pkg::OP_APPEND, 8'h00);
    push_item(smp_pkg::OP_TEXT, 8'h00);
    push_item(smp_pkg::OP_TEXT, 8'h00);
    push_item(smp_pkg::OP_TEXT, 8'h00);
    push_item(smp_pkg::OP_TEXT, 8'h01);
    push_item(smp_pkg::OP_TEXT, 8'h00);

    // Full pattern plus dropped appends, then two copies in the text.
    push_item(smp_pkg::OP_CLEAR, 8'h3C);
    for (int i = 0; i < smp_pkg::MAX_PATTERN + 2; i++) begin
      motif.insert(motif.size(), ($urandom_range(0, 1) == 0) ? 8'h5A : 8'hA5);
      push_item(smp_pkg::OP_APPEND, motif[i]);
    end
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < smp_pkg::MAX_PATTERN; i++) push_item(smp_pkg::OP_TEXT, motif[i]);
      push_item(smp_pkg::OP_TEXT, motif[0]);
    end

    while (fed < ITEM_TARGET) begin
      source_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 4) != 0) begin
          push_item(smp_pkg::OP_CLEAR, smp_pkg::symbol_t'($urandom));
        end
        foreach (alpha[i]) alpha[i] = smp_pkg::symbol_t'($urandom);
        plen = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8))
                                           : int'($urandom_range(1, 3));
        motif.delete();
        for (int i = 0; i < plen; i++) begin
          motif.insert(motif.size(), alpha[$urandom_range(0, 2)]);
          push_item(smp_pkg::OP_APPEND, motif[i]);
        end
        tlen = int'($urandom_range(4, 30));
        for (int i = 0; i < tlen; i++) begin
          r = int'($urandom_range(0, 99));
          if (r < 25) begin
            foreach (motif[k]) push_item(smp_pkg::OP_TEXT, motif[k]);
          end else if (r < 30) begin
            push_item(smp_pkg::OP_TEXT, smp_pkg::symbol_t'($urandom));
          end else if (r < 33) begin
            push_item(OP_UNUSED, smp_pkg::symbol_t'($urandom));
          end else if (r < 36) begin
            motif.insert(motif.size(), alpha[$urandom_range(0, 2)]);
            push_item(smp_pkg::OP_APPEND, motif[motif.size()-1]);
          end else begin
            push_item(smp_pkg::OP_TEXT, alpha[$urandom_range(0, 2)]);
          end
        end
      end else begin
        for (int i = 0; i < 10; i++) begin
          push_item(smp_pkg::op_t'($urandom_range(0, 3)), smp_pkg::symbol_t'($urandom));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("substring_match_positions_unit verification clean");
    end else begin
      $display("substring_match_positions_unit verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/smp_pkg.sv
rtl/smp_cell.sv
rtl/smp_out_fifo.sv
rtl/substring_match_positions_unit.sv
bench/tb_top.sv
